// ===== rtl/icc_pkg.sv =====
// Shared types and codes for the innovation covariance block.
// No dependencies; imported by every module of the block.
`default_nettype none
package icc_pkg;

  localparam logic [2:0] OP_LOAD_H    = 3'd0;
  localparam logic [2:0] OP_LOAD_P    = 3'd1;
  localparam logic [2:0] OP_LOAD_R    = 3'd2;
  localparam logic [2:0] OP_LOAD_ZM   = 3'd3;
  localparam logic [2:0] OP_LOAD_ZP   = 3'd4;
  localparam logic [2:0] OP_COMPUTE   = 3'd5;

  localparam logic KIND_COV  = 1'b0;
  localparam logic KIND_DIFF = 1'b1;

  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/icc_front.sv =====
// Front end: accepts input beats, drops unknown operations, queues commands.
// Depends on icc_pkg.
`default_nettype none
module icc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire icc_pkg::cmd_t in_cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_pop,
  output icc_pkg::cmd_t      cmd
);
  import icc_pkg::*;

  cmd_t       q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  assign in_full   = (cnt_r == 3'd4);
  assign cmd_valid = (cnt_r != 3'd0);
  assign cmd       = q_r[rd_ptr_r];

  // keep only operations that mean something
  assign wr_en = in_push && !in_full && (in_cmd.op <= OP_COMPUTE);
  assign rd_en = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 2'd1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/icc_outq.sv =====
// Result queue between the back end and the output channel.
// Depends on icc_pkg.
`default_nettype none
module icc_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire icc_pkg::res_t din,
  output logic               empty,
  input  wire logic          pop,
  output icc_pkg::res_t      dout
);
  import icc_pkg::*;

  res_t       q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       wr_en, rd_en;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = q_r[rd_ptr_r];
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/icc_back.sv =====
// Back end: holds the matrix stores, runs the covariance sequencer on a
// shared multiplier and pushes results. Depends on icc_pkg.
`default_nettype none
module icc_back #(
  parameter int MEAS_COUNT = 6,
  parameter int VAR_COUNT  = 6,
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire icc_pkg::cmd_t cmd,
  output logic               res_push,
  input  wire logic          res_full,
  output icc_pkg::res_t      res
);
  import icc_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam logic [2:0] MLAST = 3'(MEAS_COUNT - 1);
  localparam logic [2:0] VLAST = 3'(VAR_COUNT - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD1  = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_C    = 4'd4;
  localparam logic [3:0] ST_M3   = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_RRD  = 4'd7;
  localparam logic [3:0] ST_RADD = 4'd8;
  localparam logic [3:0] ST_ERD  = 4'd9;
  localparam logic [3:0] ST_EWR  = 4'd10;
  localparam logic [3:0] ST_DRD  = 4'd11;
  localparam logic [3:0] ST_DWR  = 4'd12;

  logic signed [DW-1:0] h_mem [64];
  logic signed [DW-1:0] p_mem [64];
  logic signed [DW-1:0] r_mem [64];
  logic signed [DW-1:0] s_mem [64];
  logic signed [DW-1:0] zm_mem [8];
  logic signed [DW-1:0] zp_mem [8];

  logic [3:0] state_r, state_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt, a_r, a_nxt, b_r, b_nxt;
  logic signed [DW-1:0] acc_r, acc_nxt;
  logic signed [DW-1:0] m1_r, m2_r, c_r, prod_r, pv_r;
  logic signed [DW-1:0] h1_rd_r, h2_rd_r, p_rd_r, r_rd_r, s_rd_r, zm_rd_r, zp_rd_r;

  logic [5:0] h_addr1, h_addr2, p_addr, r_addr, s_addr;
  logic [2:0] z_addr;
  logic signed [DW-1:0] ld_val, mul_a, mul_b, mul_t, c_val, s_sum;
  logic signed [2*DW-1:0] mul_full, mul_sh;
  logic [2:0] ld_lo, ld_hi;
  logic       is_load;

  assign ld_val  = DW'(cmd.value);
  assign ld_lo   = (cmd.row < cmd.col) ? cmd.row : cmd.col;
  assign ld_hi   = (cmd.row < cmd.col) ? cmd.col : cmd.row;
  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;
  assign is_load = cmd_pop && (cmd.op != OP_COMPUTE);

  // shared multiplier: exact product, arithmetic shift, wrap
  always_comb begin
    if (state_r == ST_M3) begin
      mul_a = c_r;
      mul_b = pv_r;
    end else begin
      mul_a = h1_rd_r;
      mul_b = h2_rd_r;
    end
    mul_full = mul_a * mul_b;
    mul_sh   = mul_full >>> FRAC_BITS;
    mul_t    = mul_sh[DW-1:0];
  end

  always_comb begin
    if (i_r == j_r) begin
      c_val = (a_r != b_r) ? m1_r + m1_r : m1_r;
    end else begin
      c_val = (a_r == b_r) ? m1_r : m1_r + m2_r;
    end
    s_sum = acc_r + r_rd_r;
  end

  // read addresses follow the state
  always_comb begin
    if (state_r == ST_M1) begin
      h_addr1 = {i_r, b_r};
      h_addr2 = {j_r, a_r};
    end else begin
      h_addr1 = {i_r, a_r};
      h_addr2 = {j_r, b_r};
    end
    p_addr = {a_r, b_r};
    r_addr = {i_r, j_r};
    s_addr = (i_r <= j_r) ? {i_r, j_r} : {j_r, i_r};
    z_addr = i_r;
  end

  always_ff @(posedge clk) begin
    h1_rd_r <= h_mem[h_addr1];
    h2_rd_r <= h_mem[h_addr2];
    p_rd_r  <= p_mem[p_addr];
    r_rd_r  <= r_mem[r_addr];
    s_rd_r  <= s_mem[s_addr];
    zm_rd_r <= zm_mem[z_addr];
    zp_rd_r <= zp_mem[z_addr];
    if (is_load) begin
      unique case (cmd.op)
        OP_LOAD_H:  h_mem[{cmd.row, cmd.col}] <= ld_val;
        OP_LOAD_P:  p_mem[{ld_lo, ld_hi}]     <= ld_val;
        OP_LOAD_R:  r_mem[{ld_lo, ld_hi}]     <= ld_val;
        OP_LOAD_ZM: zm_mem[cmd.row]           <= ld_val;
        default:    zp_mem[cmd.row]           <= ld_val;
      endcase
    end
    if (state_r == ST_RADD) begin
      s_mem[{i_r, j_r}] <= s_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_M1) begin
      m1_r <= mul_t;
      pv_r <= p_rd_r;
    end
    if (state_r == ST_M2) m2_r <= mul_t;
    if (state_r == ST_C) c_r <= c_val;
    if (state_r == ST_M3) prod_r <= mul_t;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    res_push  = 1'b0;
    res.kind  = KIND_COV;
    res.row   = i_r;
    res.col   = j_r;
    res.value = 32'(s_rd_r);
    res.last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop && (cmd.op == OP_COMPUTE)) begin
          i_nxt     = 3'd0;
          j_nxt     = 3'd0;
          a_nxt     = 3'd0;
          b_nxt     = 3'd0;
          acc_nxt   = '0;
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: state_nxt = ST_M1;
      ST_M1:  state_nxt = ST_M2;
      ST_M2:  state_nxt = ST_C;
      ST_C:   state_nxt = ST_M3;
      ST_M3:  state_nxt = ST_ACC;
      ST_ACC: begin
        acc_nxt = acc_r + prod_r;
        if (b_r == VLAST) begin
          if (a_r == VLAST) begin
            state_nxt = ST_RRD;
          end else begin
            a_nxt     = a_r + 3'd1;
            b_nxt     = a_r + 3'd1;
            state_nxt = ST_RD1;
          end
        end else begin
          b_nxt     = b_r + 3'd1;
          state_nxt = ST_RD1;
        end
      end
      ST_RRD: state_nxt = ST_RADD;
      ST_RADD: begin
        acc_nxt = '0;
        a_nxt   = 3'd0;
        b_nxt   = 3'd0;
        if (j_r == MLAST) begin
          if (i_r == MLAST) begin
            i_nxt     = 3'd0;
            j_nxt     = 3'd0;
            state_nxt = ST_ERD;
          end else begin
            i_nxt     = i_r + 3'd1;
            j_nxt     = i_r + 3'd1;
            state_nxt = ST_RD1;
          end
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = ST_RD1;
        end
      end
      ST_ERD: state_nxt = ST_EWR;
      ST_EWR: begin
        res_push = 1'b1;
        if (!res_full) begin
          if (j_r == MLAST) begin
            j_nxt = 3'd0;
            if (i_r == MLAST) begin
              i_nxt     = 3'd0;
              state_nxt = ST_DRD;
            end else begin
              i_nxt     = i_r + 3'd1;
              state_nxt = ST_ERD;
            end
          end else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = ST_ERD;
          end
        end
      end
      ST_DRD: state_nxt = ST_DWR;
      ST_DWR: begin
        res_push  = 1'b1;
        res.kind  = KIND_DIFF;
        res.col   = 3'd0;
        res.value = 32'(DW'(zm_rd_r - zp_rd_r));
        res.last  = (i_r == MLAST);
        if (!res_full) begin
          if (i_r == MLAST) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 3'd1;
            state_nxt = ST_DRD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/innovation_covariance_calc.sv =====
// Innovation covariance S = H P H^T + R for a Kalman update: top level.
// Depends on icc_pkg, icc_front, icc_back and icc_outq.
//
// Input channel (push/full): one beat carries operation, row, col, value.
// Operations load H, the upper triangle of P or R (a lower index pair is
// mirrored), the measured or predicted vector, or start a compute run.
// Codes above compute are dropped. A beat is taken when push is high and
// full is low; a four-entry command queue sits behind the port.
// Result channel (empty/pop): a compute run yields MEAS_COUNT^2 entries of
// S, row-major and mirrored, then MEAS_COUNT entries of measured minus
// predicted; last marks the final one. A four-entry result queue holds
// results, so the receiver may stall pop at will; the sequencer simply
// holds until space frees.
// Sequencing: the back end writes a load into its store as it pops it. A
// compute run forms the sums of the upper-triangle entries term by term on
// the single shared multiplier, used three times per term, then emits each
// result through a read state and a write state.
// Reset clears the queues and the sequencer; the stores hold whatever they
// held and must be loaded before a compute run reads them.
`default_nettype none
module innovation_covariance_calc #(
  parameter int MEAS_COUNT = 6,
  parameter int VAR_COUNT  = 6,
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [2:0]         in_operation,
  input  wire logic [2:0]         in_row,
  input  wire logic [2:0]         in_col,
  input  wire logic signed [31:0] in_value,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic                    out_kind,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [31:0]      out_result_value,
  output logic                    out_last
);
  import icc_pkg::*;

  cmd_t in_cmd, cmd;
  res_t res, res_q;
  logic cmd_valid, cmd_pop, res_push, res_full;

  // pack the input beat
  assign in_cmd.op    = in_operation;
  assign in_cmd.row   = in_row;
  assign in_cmd.col   = in_col;
  assign in_cmd.value = in_value;

  icc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  icc_back #(
    .MEAS_COUNT (MEAS_COUNT),
    .VAR_COUNT  (VAR_COUNT),
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res)
  );

  icc_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (res_q)
  );

  // unpack the oldest waiting result
  assign out_kind         = res_q.kind;
  assign out_row          = res_q.row;
  assign out_col          = res_q.col;
  assign out_result_value = res_q.value;
  assign out_last         = res_q.last;

endmodule
`default_nettype wire

// ===== sim/tb_innovation_covariance_calc.sv =====
// Self-checking testbench for innovation_covariance_calc (S = H P H^T + R).
// Depends on icc_pkg and the RTL of the block; it needs no other file.
`default_nettype none
module tb_innovation_covariance_calc;
  import icc_pkg::*;

  localparam int MEAS_N      = 6;
  localparam int VAR_N       = 6;
  localparam int FRAC        = 16;
  localparam int RAND_ITEMS  = 162;
  localparam int QUIET_TAIL  = 40;
  localparam int CYCLE_LIMIT = 5000000;

  // codes above compute, which the block drops
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic               kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic               last;
  } cov_beat_t;

  typedef struct {
    logic [2:0]         op;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    bit                 has_diff0;   // typed-in first difference entry
    logic signed [31:0] diff0;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [2:0] in_operation = '0;
  logic [2:0] in_row = '0;
  logic [2:0] in_col = '0;
  logic signed [31:0] in_value = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_kind;
  logic [2:0] out_row;
  logic [2:0] out_col;
  logic signed [31:0] out_result_value;
  logic out_last;

  // model copy of the stores
  logic signed [31:0] jac_m [8][8];
  logic signed [31:0] pcov_m [8][8];
  logic signed [31:0] noise_m [8][8];
  logic signed [31:0] zmeas_m [8];
  logic signed [31:0] zpred_m [8];

  cov_beat_t cov_expect_q[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  innovation_covariance_calc i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_row(in_row), .in_col(in_col),
    .in_value(in_value),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_kind(out_kind), .out_row(out_row), .out_col(out_col),
    .out_result_value(out_result_value), .out_last(out_last)
  );

  always #2 clk = ~clk;

  // Hard stop: far beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_innovation_covariance_calc NOT OK");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    $display("[%0d] mismatch: %s", cycle_count, what);
  endtask

  // Fixed-point product: full product, arithmetic shift, keep the low word.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return 32'(prod >>> FRAC);
  endfunction

  function automatic logic signed [31:0] innov_entry(input int i, input int j);
    logic signed [31:0] acc, c;
    acc = '0;
    for (int a = 0; a < VAR_N; a++) begin
      for (int b = a; b < VAR_N; b++) begin
        if (i == j) begin
          c = fx_mul(jac_m[i][a], jac_m[i][b]);
          if (a != b) c = c + c;
        end else if (a == b) begin
          c = fx_mul(jac_m[i][a], jac_m[j][a]);
        end else begin
          c = fx_mul(jac_m[i][a], jac_m[j][b]) + fx_mul(jac_m[i][b], jac_m[j][a]);
        end
        acc = acc + fx_mul(c, pcov_m[a][b]);
      end
    end
    return acc + noise_m[i][j];
  endfunction

  // Apply one accepted beat to the model; a compute queues its 42 results.
  task automatic predict_innovation(input logic [2:0] op, input logic [2:0] r,
                                    input logic [2:0] c, input logic signed [31:0] v);
    logic [2:0] lo, hi;
    logic signed [31:0] s [MEAS_N][MEAS_N];
    cov_beat_t e;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    case (op)
      OP_LOAD_H:  jac_m[r][c] = v;
      OP_LOAD_P:  pcov_m[lo][hi] = v;
      OP_LOAD_R:  noise_m[lo][hi] = v;
      OP_LOAD_ZM: zmeas_m[r] = v;
      OP_LOAD_ZP: zpred_m[r] = v;
      OP_COMPUTE: begin
        for (int i = 0; i < MEAS_N; i++)
          for (int j = i; j < MEAS_N; j++) s[i][j] = innov_entry(i, j);
        for (int i = 0; i < MEAS_N; i++) begin
          for (int j = 0; j < MEAS_N; j++) begin
            e.kind = KIND_COV; e.row = 3'(i); e.col = 3'(j); e.last = 1'b0;
            e.value = (i <= j) ? s[i][j] : s[j][i];
            cov_expect_q.push_back(e);
          end
        end
        for (int i = 0; i < MEAS_N; i++) begin
          e.kind = KIND_DIFF; e.row = 3'(i); e.col = '0;
          e.value = zmeas_m[i] - zpred_m[i];
          e.last = (i == MEAS_N - 1);
          cov_expect_q.push_back(e);
        end
      end
      default: ;  // spare codes: dropped
    endcase
  endtask

  // Drive one beat from the falling edge and hold it until the block takes it.
  task automatic push_beat(input logic [2:0] op, input logic [2:0] r,
                           input logic [2:0] c, input logic signed [31:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push = 1'b1;
    in_operation = op; in_row = r; in_col = c; in_value = v;
    do @(posedge clk); while (in_full);
    predict_innovation(op, r, c, v);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return $urandom_range(0, 1 << 18) - (1 << 17);
      default: return $urandom;
    endcase
  endfunction

  // Result side: random pop bursts, every taken beat checked against the queue.
  initial begin
    int stall;
    cov_beat_t e;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_pop = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        out_pop = 1'b0;
      end else begin
        out_pop = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (cov_expect_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          e = cov_expect_q.pop_front();
          if (out_kind !== e.kind) report($sformatf("kind %b exp %b", out_kind, e.kind));
          if (out_row !== e.row) report($sformatf("row %0d exp %0d", out_row, e.row));
          if (out_col !== e.col) report($sformatf("col %0d exp %0d", out_col, e.col));
          if (out_result_value !== e.value)
            report($sformatf("value %h exp %h at (%0d,%0d) kind %b",
                             out_result_value, e.value, e.row, e.col, e.kind));
          if (out_last !== e.last) report($sformatf("last %b exp %b", out_last, e.last));
        end
      end
    end
  end

  stim_row_t directed [] = '{
    '{OP_LOAD_H,  3'd0, 3'd0, 32'sh7fffffff, 1'b0, '0},
    '{OP_LOAD_H,  3'd0, 3'd1, 32'sh80000000, 1'b0, '0},
    '{OP_LOAD_P,  3'd0, 3'd0, 32'sh7fffffff, 1'b0, '0},
    '{OP_LOAD_P,  3'd1, 3'd0, 32'sh80000000, 1'b0, '0},  // lower half, mirrored
    '{OP_LOAD_R,  3'd3, 3'd1, 32'sh00000001, 1'b0, '0},  // lower half, mirrored
    '{OP_LOAD_H,  3'd7, 3'd7, -32'sd1,       1'b0, '0},  // outside the counts
    '{OP_LOAD_P,  3'd6, 3'd7, 32'sh12345678, 1'b0, '0},
    '{OP_LOAD_ZM, 3'd0, 3'd5, 32'sh7fffffff, 1'b0, '0},  // col ignored
    '{OP_LOAD_ZP, 3'd0, 3'd7, -32'sd1,       1'b0, '0},
    '{OP_SPARE_A, 3'd0, 3'd0, 32'sh55555555, 1'b0, '0},
    '{OP_SPARE_B, 3'd7, 3'd7, 32'shaaaaaaaa, 1'b0, '0},
    '{OP_COMPUTE, 3'd0, 3'd0, '0,            1'b1, 32'sh80000000},
    '{OP_LOAD_ZM, 3'd0, 3'd0, '0,            1'b0, '0},
    '{OP_LOAD_ZP, 3'd0, 3'd0, '0,            1'b0, '0},
    '{OP_LOAD_H,  3'd5, 3'd5, '0,            1'b0, '0},
    '{OP_LOAD_R,  3'd5, 3'd5, 32'sh80000000, 1'b0, '0},
    '{OP_LOAD_ZM, 3'd7, 3'd0, 32'sh7fffffff, 1'b0, '0},
    '{OP_COMPUTE, 3'd7, 3'd7, 32'shffffffff, 1'b1, 32'sh00000000}
  };

  initial begin
    logic [2:0] op, r, c;
    int waited;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Fill every store entry that a compute reads before the first compute.
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        if (i < MEAS_N && j < VAR_N) push_beat(OP_LOAD_H, 3'(i), 3'(j), pick_value());
        if (i < VAR_N && j < VAR_N && j >= i)
          push_beat(OP_LOAD_P, 3'(i), 3'(j), $urandom_range(0, 1 << 18) - (1 << 17));
        if (i < MEAS_N && j < MEAS_N && j >= i) push_beat(OP_LOAD_R, 3'(i), 3'(j), pick_value());
      end
    for (int i = 0; i < MEAS_N; i++) begin
      push_beat(OP_LOAD_ZM, 3'(i), 3'($urandom), pick_value());
      push_beat(OP_LOAD_ZP, 3'(i), 3'($urandom), pick_value());
    end

    // Directed rows; overwrite the predicted first difference where typed in.
    foreach (directed[k]) begin
      push_beat(directed[k].op, directed[k].row, directed[k].col, directed[k].value);
      if (directed[k].has_diff0)
        cov_expect_q[cov_expect_q.size() - MEAS_N].value = directed[k].diff0;
    end

    // Random part: mostly loads anywhere in the grids, some computes and spares.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if (n == RAND_ITEMS / 2) begin
        // hold off until every queued result has drained
        @(negedge clk);
        in_push = 1'b0;
        while (cov_expect_q.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 19))
        0, 1:    op = OP_COMPUTE;
        2:       op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        default: op = 3'($urandom_range(OP_LOAD_H, OP_LOAD_ZP));
      endcase
      r = 3'($urandom);
      c = 3'($urandom);
      push_beat(op, r, c, pick_value());
    end

    @(negedge clk);
    in_push = 1'b0;
    while (cov_expect_q.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 200) begin
      @(posedge clk);
      waited++;
    end

    if (mismatches == 0) begin
      $display("tb_innovation_covariance_calc OK");
    end else begin
      $display("tb_innovation_covariance_calc NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/icc_pkg.sv
rtl/icc_front.sv
rtl/icc_outq.sv
rtl/icc_back.sv
rtl/innovation_covariance_calc.sv
sim/tb_innovation_covariance_calc.sv
